>>> rtl/core/rstok_pkg.sv
`timescale 1ns / 1ps

package rstok_pkg;

    // word buffer size and derived widths
    localparam int MAX_WORD_LEN = 32;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W        = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CHAR_W       = 8;
    localparam int NUM_W        = 31;
    localparam int KIND_W       = 3;
    localparam int ERR_W        = 4;

    // command queue size
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;

    // token kinds
    typedef enum logic [KIND_W-1:0] {
        TK_WORD   = 3'd0,
        TK_NUMBER = 3'd1,
        TK_OPEN   = 3'd2,
        TK_CLOSE  = 3'd3,
        TK_LABEL  = 3'd4,
        TK_COMMA  = 3'd5,
        TK_SEMI   = 3'd6,
        TK_ERROR  = 3'd7
    } token_kind_t;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 4'd0,
        ERR_BAD_START   = 4'd1,
        ERR_BAD_WORD    = 4'd2,
        ERR_BAD_DIGIT   = 4'd3,
        ERR_AFTER_OPEN  = 4'd4,
        ERR_AFTER_CLOSE = 4'd5,
        ERR_AFTER_COLON = 4'd6,
        ERR_RANGE       = 4'd7,
        ERR_TOO_LONG    = 4'd8
    } error_code_t;

    // operations passed from the front to the back
    typedef enum logic [2:0] {
        OP_STORE      = 3'd0,
        OP_WORD       = 3'd1,
        OP_SINGLE     = 3'd2,
        OP_CLOSE_SEMI = 3'd3,
        OP_ERROR      = 3'd4
    } cmd_op_t;

    // one queued command
    typedef struct packed {
        cmd_op_t              op;
        logic [CHAR_W-1:0]    ch;
        logic [LEN_W-1:0]     len;
        logic                 semi;
        token_kind_t          kind;
        logic [NUM_W-1:0]     num;
        error_code_t          err;
    } cmd_t;

endpackage

>>> rtl/core/rstok_char_if.sv
`timescale 1ns / 1ps

interface rstok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

>>> rtl/core/rstok_token_if.sv
`timescale 1ns / 1ps

interface rstok_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  word_char;
    logic        word_end;
    logic [30:0] number_value;
    logic [3:0]  error_code;
    logic        last;

    modport source (output valid, output token_kind, output word_char, output word_end,
                    output number_value, output error_code, output last, input ready);
    modport sink (input valid, input token_kind, input word_char, input word_end,
                  input number_value, input error_code, input last, output ready);
endinterface

>>> rtl/core/routing_script_tokenizer.sv
`timescale 1ns / 1ps

// channel  | modport | payload                                                | request
// ---------+---------+--------------------------------------------------------+---------------
// chars    | sink    | char_in                                                | one input byte
// tokens   | source  | token_kind word_char word_end number_value error_code  | one result
//          |         | last                                                   |
//
// A byte is taken every cycle while the two-entry command queue has room; the
// lexer state, word length and number value update in that cycle.
// A single result is registered in the command queue and then in the output register.
// The back writes each stored word character into the word buffer, starts the buffer
// read on the word command, then drains the word, with a semicolon result after it if any.
// rst_n clears the lexer, queue and output valid at once; no clearing pass.
// A stall on tokens, or a word draining, fills the queue and then drops chars.ready.

module routing_script_tokenizer
(
    input  logic          clk,
    input  logic          rst_n,
    rstok_char_if.sink    chars,
    rstok_token_if.source tokens
);
    import rstok_pkg::*;

    cmd_t    push_cmd;
    cmd_t    pop_cmd;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    rstok_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .cmd      (push_cmd),
        .cmd_push (push),
        .cmd_full (full)
    );

    rstok_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_cmd (push_cmd),
        .push   (push),
        .full   (full),
        .rd_cmd (pop_cmd),
        .pop    (pop),
        .empty  (empty)
    );

    rstok_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_empty (empty),
        .cmd_pop   (pop),
        .tokens    (tokens)
    );

endmodule

>>> rtl/core/rstok_front.sv
`timescale 1ns / 1ps

module rstok_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    rstok_char_if.sink           chars,
    output rstok_pkg::cmd_t      cmd,
    output logic                 cmd_push,
    input  logic                 cmd_full
);
    import rstok_pkg::*;

    typedef enum logic [6:0] {
        LX_INIT  = 7'b0000001,
        LX_WORD  = 7'b0000010,
        LX_NUM   = 7'b0000100,
        LX_OPEN  = 7'b0001000,
        LX_CLOSE = 7'b0010000,
        LX_LABEL = 7'b0100000,
        LX_HALT  = 7'b1000000
    } lex_state_t;

    lex_state_t          mode_reg, mode_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [NUM_W-1:0]    acc_reg, acc_next;
    logic                ovf_reg, ovf_next;

    logic [CHAR_W-1:0]   c;
    logic                accept;
    logic                is_sep;
    logic                is_letter;
    logic                is_digit;
    logic [NUM_W-1:0]    digit;
    logic [NUM_W+3:0]    acc_times_ten;

    assign chars.ready = !cmd_full;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.char_in;

    // character classes
    assign is_sep    = (c == CH_SPACE) || (c == CH_NEWLINE);
    assign is_letter = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_digit  = c inside {[8'h30:8'h39]};
    assign digit     = {{(NUM_W-CHAR_W){1'b0}}, c - CH_ZERO};

    // running decimal value, ten times as shift and add
    assign acc_times_ten = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                           + {4'b0000, digit};

    // lexer step for one accepted byte
    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        cmd_push  = 1'b0;
        cmd       = '{op: OP_SINGLE, ch: '0, len: '0, semi: 1'b0, kind: TK_WORD,
                      num: '0, err: ERR_NONE};
        if (accept)
        begin
            case (mode_reg)
                LX_INIT:
                begin
                    if (is_sep)
                    begin
                        mode_next = LX_INIT;
                    end
                    else if (c == CH_OPEN)
                    begin
                        mode_next = LX_OPEN;
                    end
                    else if (c == CH_CLOSE)
                    begin
                        mode_next = LX_CLOSE;
                    end
                    else if (c == CH_COLON)
                    begin
                        mode_next = LX_LABEL;
                    end
                    else if (c == CH_COMMA)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = TK_COMMA;
                    end
                    else if (is_letter)
                    begin
                        cmd_push  = 1'b1;
                        cmd.op    = OP_STORE;
                        cmd.ch    = c;
                        cmd.len   = '0;
                        len_next  = LEN_W'(1);
                        mode_next = LX_WORD;
                    end
                    else if (is_digit)
                    begin
                        acc_next  = digit;
                        ovf_next  = 1'b0;
                        mode_next = LX_NUM;
                    end
                    else
                    begin
                        cmd_push  = 1'b1;
                        cmd.op    = OP_ERROR;
                        cmd.err   = ERR_BAD_START;
                        mode_next = LX_HALT;
                    end
                end
                LX_WORD:
                begin
                    if (is_sep || c == CH_SEMI)
                    begin
                        cmd_push  = 1'b1;
                        cmd.op    = OP_WORD;
                        cmd.len   = len_reg;
                        cmd.semi  = (c == CH_SEMI);
                        len_next  = '0;
                        acc_next  = '0;
                        ovf_next  = 1'b0;
                        mode_next = LX_INIT;
                    end
                    else if (is_letter || is_digit)
                    begin
                        cmd_push = 1'b1;
                        if (len_reg >= LEN_W'(MAX_WORD_LEN))
                        begin
                            cmd.op    = OP_ERROR;
                            cmd.err   = ERR_TOO_LONG;
                            mode_next = LX_HALT;
                        end
                        else
                        begin
                            cmd.op   = OP_STORE;
                            cmd.ch   = c;
                            cmd.len  = len_reg;
                            len_next = len_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_push  = 1'b1;
                        cmd.op    = OP_ERROR;
                        cmd.err   = ERR_BAD_WORD;
                        mode_next = LX_HALT;
                    end
                end
                LX_NUM:
                begin
                    if (is_sep)
                    begin
                        cmd_push = 1'b1;
                        if (ovf_reg)
                        begin
                            cmd.op    = OP_ERROR;
                            cmd.err   = ERR_RANGE;
                            mode_next = LX_HALT;
                        end
                        else
                        begin
                            cmd.kind  = TK_NUMBER;
                            cmd.num   = acc_reg;
                            len_next  = '0;
                            acc_next  = '0;
                            ovf_next  = 1'b0;
                            mode_next = LX_INIT;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (!ovf_reg)
                        begin
                            if (acc_times_ten[NUM_W+3:NUM_W] != 4'b0000)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = acc_times_ten[NUM_W-1:0];
                            end
                        end
                    end
                    else
                    begin
                        cmd_push  = 1'b1;
                        cmd.op    = OP_ERROR;
                        cmd.err   = ERR_BAD_DIGIT;
                        mode_next = LX_HALT;
                    end
                end
                LX_OPEN:
                begin
                    cmd_push = 1'b1;
                    if (c == CH_SPACE)
                    begin
                        cmd.kind  = TK_OPEN;
                        mode_next = LX_INIT;
                    end
                    else
                    begin
                        cmd.op    = OP_ERROR;
                        cmd.err   = ERR_AFTER_OPEN;
                        mode_next = LX_HALT;
                    end
                end
                LX_CLOSE:
                begin
                    cmd_push = 1'b1;
                    if (is_sep)
                    begin
                        cmd.kind  = TK_CLOSE;
                        mode_next = LX_INIT;
                    end
                    else if (c == CH_SEMI)
                    begin
                        cmd.op    = OP_CLOSE_SEMI;
                        mode_next = LX_INIT;
                    end
                    else
                    begin
                        cmd.op    = OP_ERROR;
                        cmd.err   = ERR_AFTER_CLOSE;
                        mode_next = LX_HALT;
                    end
                end
                LX_LABEL:
                begin
                    cmd_push = 1'b1;
                    if (is_sep)
                    begin
                        cmd.kind  = TK_LABEL;
                        mode_next = LX_INIT;
                    end
                    else
                    begin
                        cmd.op    = OP_ERROR;
                        cmd.err   = ERR_AFTER_COLON;
                        mode_next = LX_HALT;
                    end
                end
                LX_HALT:
                begin
                    mode_next = LX_HALT;
                end
                default:
                begin
                    mode_next = LX_HALT;
                end
            endcase
        end
    end

    // lexer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= LX_INIT;
            len_reg  <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

`ifndef SYNTH
    // once halted, only reset leaves the halt
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == LX_HALT) |=> (mode_reg == LX_HALT))
        else $error("lexer left the halted state");

    // a halted lexer queues nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == LX_HALT) |-> !cmd_push)
        else $error("command queued while halted");

    // the word length never exceeds the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("word length beyond the buffer");
`endif

endmodule

>>> rtl/core/rstok_queue.sv
`timescale 1ns / 1ps

module rstok_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rstok_pkg::cmd_t      wr_cmd,
    input  logic                 push,
    output logic                 full,
    output rstok_pkg::cmd_t      rd_cmd,
    input  logic                 pop,
    output logic                 empty
);
    import rstok_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

`ifndef SYNTH
    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full command queue");
`endif

endmodule

>>> rtl/core/rstok_back.sv
`timescale 1ns / 1ps

module rstok_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rstok_pkg::cmd_t      cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    rstok_token_if.source        tokens
);
    import rstok_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_WORD = 3'b010,
        BK_SEMI = 3'b100
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    wlen_reg, wlen_next;
    logic                semi_reg, semi_next;
    logic [LEN_W-1:0]    cnt_inc;

    // word buffer
    logic [CHAR_W-1:0]   word_mem [MAX_WORD_LEN];
    logic [CHAR_W-1:0]   rdata_reg;
    logic [IDX_W-1:0]    raddr;
    logic                wr_en;

    // output register
    logic                ovalid_reg, ovalid_next;
    token_kind_t         okind_reg, okind_next;
    logic [CHAR_W-1:0]   ochar_reg, ochar_next;
    logic                oend_reg, oend_next;
    logic [NUM_W-1:0]    onum_reg, onum_next;
    error_code_t         oerr_reg, oerr_next;
    logic                olast_reg, olast_next;
    logic                load;
    logic                out_free;
    logic                is_final;

    assign out_free = !ovalid_reg || tokens.ready;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign is_final = (cnt_inc == wlen_reg);

    // command execution
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wlen_next  = wlen_reg;
        semi_next  = semi_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        load       = 1'b0;
        raddr      = cnt_reg[IDX_W-1:0];
        okind_next = TK_WORD;
        ochar_next = '0;
        oend_next  = 1'b0;
        onum_next  = '0;
        oerr_next  = ERR_NONE;
        olast_next = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (cmd.op)
                        OP_STORE:
                        begin
                            cmd_pop = 1'b1;
                            wr_en   = 1'b1;
                        end
                        OP_WORD:
                        begin
                            cmd_pop    = 1'b1;
                            cnt_next   = '0;
                            wlen_next  = cmd.len;
                            semi_next  = cmd.semi;
                            raddr      = '0;
                            state_next = BK_WORD;
                        end
                        OP_SINGLE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop    = 1'b1;
                                load       = 1'b1;
                                okind_next = cmd.kind;
                                onum_next  = cmd.num;
                                olast_next = 1'b1;
                            end
                        end
                        OP_CLOSE_SEMI:
                        begin
                            if (out_free)
                            begin
                                cmd_pop    = 1'b1;
                                load       = 1'b1;
                                okind_next = TK_CLOSE;
                                state_next = BK_SEMI;
                            end
                        end
                        OP_ERROR:
                        begin
                            if (out_free)
                            begin
                                cmd_pop    = 1'b1;
                                load       = 1'b1;
                                okind_next = TK_ERROR;
                                oerr_next  = cmd.err;
                                olast_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_WORD:
            begin
                // one character per free output slot, next read set up behind it
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = TK_WORD;
                    ochar_next = rdata_reg;
                    oend_next  = is_final;
                    olast_next = is_final && !semi_reg;
                    cnt_next   = cnt_inc;
                    raddr      = cnt_inc[IDX_W-1:0];
                    if (is_final)
                    begin
                        state_next = semi_reg ? BK_SEMI : BK_IDLE;
                    end
                end
            end
            BK_SEMI:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = TK_SEMI;
                    olast_next = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign ovalid_next = load ? 1'b1 : (tokens.ready ? 1'b0 : ovalid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            cnt_reg    <= '0;
            wlen_reg   <= '0;
            semi_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            wlen_reg   <= wlen_next;
            semi_reg   <= semi_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            okind_reg <= okind_next;
            ochar_reg <= ochar_next;
            oend_reg  <= oend_next;
            onum_reg  <= onum_next;
            oerr_reg  <= oerr_next;
            olast_reg <= olast_next;
        end
    end

    // word buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[cmd.len[IDX_W-1:0]] <= cmd.ch;
        end
        rdata_reg <= word_mem[raddr];
    end

    assign tokens.valid        = ovalid_reg;
    assign tokens.token_kind   = okind_reg;
    assign tokens.word_char    = ochar_reg;
    assign tokens.word_end     = oend_reg;
    assign tokens.number_value = onum_reg;
    assign tokens.error_code   = oerr_reg;
    assign tokens.last         = olast_reg;

`ifndef SYNTH
    // an error result always closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && okind_reg == TK_ERROR) |-> olast_reg)
        else $error("error result without last");

    // word end only marks word characters
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oend_reg) |-> (okind_reg == TK_WORD))
        else $error("word end on a non-word result");
`endif

endmodule

>>> dv/tb_routing_script_tokenizer.sv
`timescale 1ns / 1ps

module tb_routing_script_tokenizer;

    import rstok_pkg::*;

    localparam logic [30:0] NUMBER_CEILING = 31'h7FFF_FFFF;

    // lexer position as the predictor tracks it
    typedef enum
    {
        LX_INIT,
        LX_WORD,
        LX_NUMBER,
        LX_OPEN,
        LX_CLOSE,
        LX_LABEL,
        LX_HALT
    } lex_mode_t;

    // one token result, field by field
    typedef struct
    {
        token_kind_t kind;
        logic [7:0]  wchar;
        logic        wend;
        logic [30:0] value;
        error_code_t code;
        logic        last;
    } token_t;

    // tracks the lexer and holds the tokens still owed by the block
    class token_tracker;
        lex_mode_t   mode;
        logic [7:0]  spelling [MAX_WORD_LEN];
        int          spelled;
        logic [30:0] total;
        bit          overran;
        token_t      due_tokens [$];
        int          failures;

        function new();
            settle();
            failures = 0;
        endfunction

        function void settle();
            spelled = 0;
            total   = '0;
            overran = 1'b0;
            mode    = LX_INIT;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_gap(logic [7:0] c);
            return c == CH_SPACE || c == CH_NEWLINE;
        endfunction

        function void owe(token_kind_t k, logic [7:0] ch, logic we, logic [30:0] v,
                          error_code_t e, logic l);
            token_t t;
            t.kind  = k;
            t.wchar = ch;
            t.wend  = we;
            t.value = v;
            t.code  = e;
            t.last  = l;
            due_tokens.insert(due_tokens.size(), t);
        endfunction

        // error that this byte would raise in the present mode, without moving on
        function error_code_t fault_of(logic [7:0] c);
            case (mode)
                LX_INIT:
                    if (!(is_gap(c) || c == CH_OPEN || c == CH_CLOSE || c == CH_COLON ||
                          c == CH_COMMA || is_letter(c) || is_digit(c)))
                        return ERR_BAD_START;
                LX_WORD:
                    if (is_letter(c) || is_digit(c))
                    begin
                        if (spelled >= MAX_WORD_LEN)
                            return ERR_TOO_LONG;
                    end
                    else if (!is_gap(c) && c != CH_SEMI)
                        return ERR_BAD_WORD;
                LX_NUMBER:
                    if (is_gap(c))
                    begin
                        if (overran)
                            return ERR_RANGE;
                    end
                    else if (!is_digit(c))
                        return ERR_BAD_DIGIT;
                LX_OPEN:
                    if (c != CH_SPACE)
                        return ERR_AFTER_OPEN;
                LX_CLOSE:
                    if (!is_gap(c) && c != CH_SEMI)
                        return ERR_AFTER_CLOSE;
                LX_LABEL:
                    if (!is_gap(c))
                        return ERR_AFTER_COLON;
                default: ;
            endcase
            return ERR_NONE;
        endfunction

        // advance the lexer by one accepted byte and note the tokens it owes
        function void take_char(logic [7:0] c);
            error_code_t     err;
            longint unsigned grown;
            bit              semi;
            err  = fault_of(c);
            semi = (c == CH_SEMI);
            if (mode == LX_HALT)
                return;
            if (err != ERR_NONE)
            begin
                owe(TK_ERROR, 8'd0, 1'b0, '0, err, 1'b1);
                mode = LX_HALT;
                return;
            end
            case (mode)
                LX_INIT:
                    if (c == CH_OPEN)
                        mode = LX_OPEN;
                    else if (c == CH_CLOSE)
                        mode = LX_CLOSE;
                    else if (c == CH_COLON)
                        mode = LX_LABEL;
                    else if (c == CH_COMMA)
                        owe(TK_COMMA, 8'd0, 1'b0, '0, ERR_NONE, 1'b1);
                    else if (is_letter(c))
                    begin
                        spelling[0] = c;
                        spelled     = 1;
                        mode        = LX_WORD;
                    end
                    else if (is_digit(c))
                    begin
                        total   = 31'(c - CH_ZERO);
                        overran = 1'b0;
                        mode    = LX_NUMBER;
                    end
                LX_WORD:
                    if (is_gap(c) || semi)
                    begin
                        for (int i = 0; i < spelled; i++)
                            owe(TK_WORD, spelling[i], i == spelled - 1, '0, ERR_NONE,
                                i == spelled - 1 && !semi);
                        if (semi)
                            owe(TK_SEMI, 8'd0, 1'b0, '0, ERR_NONE, 1'b1);
                        settle();
                    end
                    else
                    begin
                        spelling[spelled] = c;
                        spelled++;
                    end
                LX_NUMBER:
                    if (is_gap(c))
                    begin
                        owe(TK_NUMBER, 8'd0, 1'b0, total, ERR_NONE, 1'b1);
                        settle();
                    end
                    else if (!overran)
                    begin
                        grown = longint'(total) * 10 + longint'(c - CH_ZERO);
                        if (grown > NUMBER_CEILING)
                            overran = 1'b1;
                        else
                            total = 31'(grown);
                    end
                LX_OPEN:
                begin
                    owe(TK_OPEN, 8'd0, 1'b0, '0, ERR_NONE, 1'b1);
                    settle();
                end
                LX_CLOSE:
                begin
                    owe(TK_CLOSE, 8'd0, 1'b0, '0, ERR_NONE, !semi);
                    if (semi)
                        owe(TK_SEMI, 8'd0, 1'b0, '0, ERR_NONE, 1'b1);
                    settle();
                end
                LX_LABEL:
                begin
                    owe(TK_LABEL, 8'd0, 1'b0, '0, ERR_NONE, 1'b1);
                    settle();
                end
                default: ;
            endcase
        endfunction

        // compare one token from the block against the oldest owed one
        function void compare_token(token_t got);
            token_t want;
            if (due_tokens.size() == 0)
            begin
                $error("unexpected token result: token_kind %0d", got.kind);
                failures++;
                return;
            end
            want = due_tokens.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
                failures++;
            end
            if (got.wchar !== want.wchar)
            begin
                $error("word_char: expected %0d, got %0d", want.wchar, got.wchar);
                failures++;
            end
            if (got.wend !== want.wend)
            begin
                $error("word_end: expected %0d, got %0d", want.wend, got.wend);
                failures++;
            end
            if (got.value !== want.value)
            begin
                $error("number_value: expected %0d, got %0d", want.value, got.value);
                failures++;
            end
            if (got.code !== want.code)
            begin
                $error("error_code: expected %0d, got %0d", want.code, got.code);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    bit           idle_on;
    int           chars_sent;
    token_t       seen;
    token_tracker tracker;

    rstok_char_if  chars_if ();
    rstok_token_if tokens_if ();

    routing_script_tokenizer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if.sink),
        .tokens (tokens_if.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hard stop
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // token side back-pressure in bursts
    initial
    begin
        tokens_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                tokens_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            tokens_if.ready <= 1'b1;
        end
    end

    // capture each token request
    always @(posedge clk)
    begin
        if (rst_n && tokens_if.valid && tokens_if.ready)
        begin
            seen.kind  = token_kind_t'(tokens_if.token_kind);
            seen.wchar = tokens_if.word_char;
            seen.wend  = tokens_if.word_end;
            seen.value = tokens_if.number_value;
            seen.code  = error_code_t'(tokens_if.error_code);
            seen.last  = tokens_if.last;
            tracker.compare_token(seen);
        end
    end

    // one byte request, with an optional gap ahead of it
    task automatic send_char(logic [7:0] c);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        tracker.take_char(c);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] any_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] any_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 10) ? 8'(CH_ZERO + r) : any_letter();
    endfunction

    function automatic logic [7:0] any_gap();
        return $urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE;
    endfunction

    // word of the given length, without its terminator
    task automatic send_word(int len);
        send_char(any_letter());
        for (int i = 1; i < len; i++)
            send_char(any_alnum());
    endtask

    // decimal text of a value and a gap after it, sometimes with leading zeros
    task automatic send_number(logic [30:0] v);
        logic [7:0] digits [$];
        if (v == 0)
            digits.push_front(CH_ZERO);
        while (v != 0)
        begin
            digits.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) digits.push_front(CH_ZERO);
        foreach (digits[i])
            send_char(digits[i]);
        send_char(any_gap());
    endtask

    // one well-formed token with random content
    task automatic send_token();
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 5) == 0)
            send_char(any_gap());
        if (pick < 40)
        begin
            send_word(($urandom_range(0, 19) == 0) ? MAX_WORD_LEN : $urandom_range(1, 8));
            send_char(($urandom_range(0, 3) == 0) ? CH_SEMI : any_gap());
        end
        else if (pick < 65)
        begin
            case ($urandom_range(0, 9))
                0:       send_number(NUMBER_CEILING);
                1, 2:    send_number(31'($urandom));
                default: send_number(31'($urandom_range(0, 999)));
            endcase
        end
        else if (pick < 73)
        begin
            send_char(CH_OPEN);
            send_char(CH_SPACE);
        end
        else if (pick < 83)
        begin
            send_char(CH_CLOSE);
            send_char(($urandom_range(0, 2) == 0) ? CH_SEMI : any_gap());
        end
        else if (pick < 90)
        begin
            send_char(CH_COLON);
            send_char(any_gap());
        end
        else
            send_char(CH_COMMA);
    endtask

    // lead the lexer into one chosen error, which halts it for good
    task automatic send_fault(error_code_t want);
        logic [7:0] c;
        case (want)
            ERR_BAD_WORD:    send_char(any_letter());
            ERR_BAD_DIGIT:   send_char(8'(CH_ZERO + $urandom_range(0, 9)));
            ERR_AFTER_OPEN:  send_char(CH_OPEN);
            ERR_AFTER_CLOSE: send_char(CH_CLOSE);
            ERR_AFTER_COLON: send_char(CH_COLON);
            ERR_RANGE:
            begin
                // ten digits from 3 upward always pass the ceiling, then up to three more digits
                send_char(8'(CH_ZERO + $urandom_range(3, 9)));
                repeat (9 + $urandom_range(0, 3))
                    send_char(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            ERR_TOO_LONG:    send_word(MAX_WORD_LEN);
            default: ;
        endcase
        do
            c = 8'($urandom_range(0, 255));
        while (tracker.fault_of(c) != want);
        send_char(c);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.char_in = 8'd0;
        idle_on          = 1'b1;
        chars_sent       = 0;
        tracker          = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every token kind but the error, both semicolon forms, zero and the largest number
        send_text("( Za09;) :\n,0\n2147483647 x\n);");
        send_word(MAX_WORD_LEN);
        send_char(CH_SEMI);

        // random well-formed text, calm towards the end
        while (chars_sent < 390)
        begin
            if (chars_sent > 330)
                idle_on = 1'b0;
            else if ($urandom_range(0, 15) == 0)
                idle_on = !idle_on;
            send_token();
        end

        // one error, then bytes that the halted lexer must swallow
        send_fault(error_code_t'($urandom_range(1, 8)));
        send_char(8'hFF);
        send_char(8'h00);
        repeat (10) send_char(8'($urandom_range(0, 255)));
        @(negedge clk);
        chars_if.valid <= 1'b0;

        // drain, then watch for stray tokens
        while (tracker.due_tokens.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (tracker.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
